/* src/lir_pkg.sv */
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

	localparam int TARGET_RATE_DEF = 16000;
	localparam int RATE_FLOOR      = 4000;
	localparam int RATE_CEIL       = 192000;
	localparam int RATE_RESET      = 16000;
	localparam int MAX_RESULTS     = 8;
	localparam int RATE_W          = 18;

	// offset binary conversion of a 16-bit sample
	localparam logic [15:0] SIGN_FLIP = 16'h8000;

	typedef logic signed [15:0] sample_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PEND,
		S_LOOP,
		S_WAIT,
		S_TAIL,
		S_FLUSH
	} lir_seq_state_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL0,
		U_MUL1,
		U_ADD,
		U_RECIP,
		U_BACK,
		U_FIX
	} lir_unit_state_t;

	typedef struct packed {
		logic        start;
		sample_t     a;
		sample_t     b;
		logic [15:0] r;
	} lir_lerp_req_t;

	typedef struct packed {
		logic    valid;
		sample_t value;
	} lir_lerp_rsp_t;

endpackage

/* src/lir_in_if.sv */
// ----------------------------------------------------------------------------
// lir_in_if
// Input sample channel: valid/ready handshake with one sample word.
// ----------------------------------------------------------------------------
interface lir_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;
	logic               stream_end;

	modport source (output valid, output sample_in, output stream_end, input ready);
	modport sink (input valid, input sample_in, input stream_end, output ready);
endinterface

/* src/lir_out_if.sv */
// ----------------------------------------------------------------------------
// lir_out_if
// Output sample channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface lir_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               run_last;
	logic               stream_done;

	modport source (output valid, output sample_out, output run_last, output stream_done,
		input ready);
	modport sink (input valid, input sample_out, input run_last, input stream_done,
		output ready);
endinterface

/* src/lir_cfg_if.sv */
// ----------------------------------------------------------------------------
// lir_cfg_if
// Configuration write channel carrying the input rate register.
// ----------------------------------------------------------------------------
interface lir_cfg_if;
	logic        valid;
	logic        ready;
	logic [17:0] rate_hz;

	modport source (output valid, output rate_hz, input ready);
	modport sink (input valid, input rate_hz, output ready);
endinterface

/* src/lir_lerp_unit.sv */
// ----------------------------------------------------------------------------
// lir_lerp_unit
// Shared interpolation unit: one multiplier forms both products, then a
// reciprocal multiply by 2^32/T and a back multiply with a one-step
// correction give the floored quotient.
// ----------------------------------------------------------------------------
module lir_lerp_unit #(
	parameter int TARGET_RATE = lir_pkg::TARGET_RATE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lir_pkg::lir_lerp_req_t req,
	output lir_pkg::lir_lerp_rsp_t rsp
);
	import lir_pkg::*;

	localparam logic [15:0] T_C     = 16'(TARGET_RATE);
	localparam logic [19:0] T_C20   = 20'(TARGET_RATE);
	localparam logic [31:0] T_C32   = 32'(TARGET_RATE);
	localparam logic [31:0] T2_C32  = 32'(2 * TARGET_RATE);
	// floor(2^32 / T): the quotient estimate is low by at most one
	localparam logic [19:0] RECIP_C = 20'(64'h1_0000_0000 / 64'(TARGET_RATE));

	lir_unit_state_t state_q, state_d;

	logic [15:0] ua_q, ub_q, r_q, qest_q, num_q;
	logic [31:0] prod_s1, acc_q, sum_q;
	logic        vld_q;

	logic        ld_prod, ld_acc, ld_sum, ld_qest, ld_fix;
	logic [31:0] mul_x;
	logic [19:0] mul_y;
	logic [47:0] prod;
	logic [31:0] fix_rem;
	logic        fix_up;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_IDLE:  if (req.start) state_d = U_MUL0;
			U_MUL0:  state_d = U_MUL1;
			U_MUL1:  state_d = U_ADD;
			U_ADD:   state_d = U_RECIP;
			U_RECIP: state_d = U_BACK;
			U_BACK:  state_d = U_FIX;
			U_FIX:   state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	// step controls and multiplier operands
	always_comb begin
		mul_x   = {16'b0, ua_q};
		mul_y   = {4'b0, T_C - r_q};
		ld_prod = 1'b0;
		ld_acc  = 1'b0;
		ld_sum  = 1'b0;
		ld_qest = 1'b0;
		ld_fix  = 1'b0;
		unique case (state_q)
			U_IDLE: ;
			U_MUL0: ld_prod = 1'b1;
			U_MUL1: begin
				mul_x   = {16'b0, ub_q};
				mul_y   = {4'b0, r_q};
				ld_prod = 1'b1;
				ld_acc  = 1'b1;
			end
			U_ADD:   ld_sum = 1'b1;
			U_RECIP: begin
				mul_x   = sum_q;
				mul_y   = RECIP_C;
				ld_qest = 1'b1;
			end
			U_BACK: begin
				mul_x   = {16'b0, qest_q};
				mul_y   = T_C20;
				ld_prod = 1'b1;
			end
			U_FIX:   ld_fix = 1'b1;
			default: ;
		endcase
	end

	// a*(T-r) + b*r in offset binary, so the sum stays non-negative
	assign prod    = 48'(mul_x) * 48'(mul_y);
	assign fix_rem = sum_q - prod_s1;
	assign fix_up  = (fix_rem >= T_C32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == U_IDLE && req.start) vld_q <= 1'b0;
			else if (ld_fix) vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && req.start) begin
			ua_q <= req.a ^ SIGN_FLIP;
			ub_q <= req.b ^ SIGN_FLIP;
			r_q  <= req.r;
		end
		if (ld_prod) prod_s1 <= prod[31:0];
		if (ld_acc) acc_q <= prod_s1;
		if (ld_sum) sum_q <= acc_q + prod_s1;
		// sum is below 2^16 * T, so the quotient fits 16 bits
		if (ld_qest) qest_q <= prod[47:32];
		if (ld_fix) num_q <= fix_up ? qest_q + 16'd1 : qest_q;
	end

	assign rsp.valid = vld_q;
	assign rsp.value = sample_t'(num_q ^ SIGN_FLIP);

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == U_IDLE)
		else $error("interpolation started while unit busy");

	a_valid_after_fix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q) == U_FIX)
		else $error("result valid without a finished quotient");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == U_FIX |-> fix_rem < T2_C32)
		else $error("quotient estimate off by more than one");
`endif
endmodule

/* src/linear_interp_resampler_core.sv */
// ----------------------------------------------------------------------------
// linear_interp_resampler_core
// Streaming linear interpolation resampler to a fixed target rate, with an
// exact rational position and a floored interpolation.
// ----------------------------------------------------------------------------
//   channel   dir   word                                    handshake
//   cfg       in    rate_hz (18b)                           valid/ready
//   samples   in    sample_in (16b signed), stream_end      valid/ready
//   results   out   sample_out (16b signed), run_last,      valid/ready
//                   stream_done
//
//   each interpolated output of a sample runs the six steps of the shared
//   multiplier unit; trailing outputs at stream end and the first sample of
//   a stream use no multiply; no new word is taken meanwhile
//   reset: asynchronous, no clearing pass; the rate register resets to 16000
//   a stalled results channel holds the sequencer once the output register
//   and the one-word lookahead are both full
// ----------------------------------------------------------------------------
module linear_interp_resampler_core #(
	parameter int TARGET_RATE = lir_pkg::TARGET_RATE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lir_cfg_if.sink    cfg,
	lir_in_if.sink     samples,
	lir_out_if.source  results
);
	import lir_pkg::*;

	localparam int          RATE_QTR = (TARGET_RATE + 3) / 4;
	localparam int          RATE_LO  = (RATE_FLOOR > RATE_QTR) ? RATE_FLOOR : RATE_QTR;
	localparam logic [19:0] T1W      = 20'(TARGET_RATE);
	localparam logic [19:0] T2W      = 20'(2 * TARGET_RATE);
	localparam int          NW       = $clog2(MAX_RESULTS + 1);

	lir_seq_state_t state_q, state_d;

	logic [RATE_W-1:0] rate_cfg_q, rate_sat, rate_q;
	sample_t           prev_q, x_q, pend_q, held_val_q, out_val_q;
	logic              have_q, pend_valid_q, held_q, out_valid_q, end_q;
	logic [17:0]       pos_q;
	logic [18:0]       r_q;
	logic [NW-1:0]     n_q;
	logic              out_last_q, out_done_q;

	lir_lerp_req_t lerp_req;
	lir_lerp_rsp_t lerp_rsp;

	logic        in_ready, accept;
	logic        emit_req, emit_fire, emit_stall, can_emit, out_free, n_full;
	sample_t     emit_val;
	logic        start_lerp, flush_push, flush_exit, out_load;
	logic [19:0] sum_r;
	logic        r_below_t, fits2, tail_fits;

	lir_lerp_unit #(
		.TARGET_RATE(TARGET_RATE)
	) u_lerp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (lerp_req),
		.rsp   (lerp_rsp)
	);

	always_comb begin
		if (rate_cfg_q < RATE_W'(RATE_LO)) rate_sat = RATE_W'(RATE_LO);
		else if (rate_cfg_q > RATE_W'(RATE_CEIL)) rate_sat = RATE_W'(RATE_CEIL);
		else rate_sat = rate_cfg_q;
	end

	assign sum_r     = {1'b0, r_q} + 20'(rate_q);
	assign r_below_t = ({1'b0, r_q} < T1W);
	assign fits2     = (sum_r <= T2W);
	assign tail_fits = (sum_r <= T1W);

	assign accept     = samples.valid && in_ready;
	assign out_free   = !out_valid_q || results.ready;
	assign can_emit   = !held_q || out_free;
	assign n_full     = (n_q == NW'(MAX_RESULTS));
	// beyond the result limit a word is simply dropped
	assign emit_fire  = emit_req && !n_full && can_emit;
	assign emit_stall = emit_req && !n_full && !can_emit;
	assign flush_exit = (state_q == S_FLUSH) && (!held_q || out_free);
	assign out_load   = (emit_fire && held_q) || flush_push;

	// sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		emit_req   = 1'b0;
		emit_val   = x_q;
		start_lerp = 1'b0;
		flush_push = 1'b0;
		unique case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_PEND: begin
				emit_req = pend_valid_q && ({1'b0, r_q} <= T2W);
				emit_val = pend_q;
			end
			S_LOOP:  start_lerp = r_below_t;
			S_WAIT: begin
				emit_req = lerp_rsp.valid && fits2;
				emit_val = lerp_rsp.value;
			end
			S_TAIL:  emit_req = end_q && tail_fits;
			S_FLUSH: flush_push = held_q && out_free;
			default: ;
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = have_q ? S_PEND : S_TAIL;
			S_PEND:  if (!emit_stall) state_d = S_LOOP;
			S_LOOP:  state_d = r_below_t ? S_WAIT : S_TAIL;
			S_WAIT:  if (lerp_rsp.valid && !emit_stall) state_d = S_LOOP;
			S_TAIL:  if (!(end_q && tail_fits)) state_d = S_FLUSH;
			S_FLUSH: if (flush_exit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign lerp_req.start = start_lerp;
	assign lerp_req.a     = prev_q;
	assign lerp_req.b     = x_q;
	assign lerp_req.r     = r_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rate_cfg_q   <= RATE_W'(RATE_RESET);
			have_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			held_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			n_q          <= '0;
			pos_q        <= '0;
			prev_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) rate_cfg_q <= cfg.rate_hz;

			if (out_load) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;

			if (accept) begin
				held_q <= 1'b0;
				n_q    <= '0;
			end else if (emit_fire) begin
				held_q <= 1'b1;
				n_q    <= n_q + 1'b1;
			end else if (flush_exit) begin
				held_q <= 1'b0;
			end

			if (state_q == S_PEND && emit_req && !emit_stall) pend_valid_q <= 1'b0;
			else if (state_q == S_WAIT && lerp_rsp.valid && !fits2) pend_valid_q <= 1'b1;
			else if (flush_exit && end_q) pend_valid_q <= 1'b0;

			if (flush_exit) begin
				if (end_q) begin
					prev_q <= '0;
					have_q <= 1'b0;
					pos_q  <= '0;
				end else begin
					prev_q <= x_q;
					have_q <= 1'b1;
					pos_q  <= r_q[17:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= samples.sample_in;
			end_q  <= samples.stream_end;
			rate_q <= rate_sat;
			r_q    <= {1'b0, pos_q};
		end else if (state_q == S_LOOP && !r_below_t) begin
			r_q <= 19'({1'b0, r_q} - T1W);
		end else if (state_q == S_WAIT && lerp_rsp.valid && !emit_stall) begin
			r_q <= sum_r[18:0];
		end else if (state_q == S_TAIL && emit_req && !emit_stall) begin
			r_q <= sum_r[18:0];
		end

		if (state_q == S_WAIT && lerp_rsp.valid && !fits2) pend_q <= lerp_rsp.value;
		if (emit_fire) held_val_q <= emit_val;

		// previous word goes out once the next one is known
		if (out_load) begin
			out_val_q  <= held_val_q;
			out_last_q <= flush_push;
			out_done_q <= flush_push && end_q;
		end
	end

	assign cfg.ready           = 1'b1;
	assign samples.ready       = in_ready;
	assign results.valid       = out_valid_q;
	assign results.sample_out  = out_val_q;
	assign results.run_last    = out_last_q;
	assign results.stream_done = out_done_q;

`ifndef SYNTH
	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !held_q)
		else $error("lookahead word left behind at item end");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MAX_RESULTS))
		else $error("result count beyond limit");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.stream_done |-> results.run_last)
		else $error("stream_done without run_last");

	a_wait_position: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAIT |-> r_below_t)
		else $error("interpolation position outside current interval");
`endif
endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the linear interpolation resampler core. A scoreboard class
// predicts every result word from the accepted samples and the input rate in
// force, and checks the output channel word by word in order. Directed streams
// cover the sample extremes, the rate limits and out-of-range rates. Random
// streams follow, with random idling on both channels and one long output
// stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
	import lir_pkg::*;

	localparam int TGT           = TARGET_RATE_DEF;
	localparam int IDLE_PCT      = 32;
	localparam int RANDOM_ITEMS  = 130;
	localparam int SETTLE_CYCLES = 250;
	localparam int HOLD_CYCLES   = 400;
	localparam int HANG_LIMIT    = 4000;

	typedef struct packed {
		sample_t value;
		logic    run_last;
		logic    stream_done;
	} result_word_t;

	class resample_scoreboard;
		logic [RATE_W-1:0] rate_reg;
		sample_t           last_sample;
		bit                have_last;
		int unsigned       phase_rem;
		bit                held_valid;
		sample_t           held_sample;
		result_word_t      expected_q[$];
		int                errors;
		int                samples_seen;
		int                words_seen;
		int                streams_closed;

		function new();
			rate_reg       = RATE_W'(RATE_RESET);
			errors         = 0;
			samples_seen   = 0;
			words_seen     = 0;
			streams_closed = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			last_sample = '0;
			have_last   = 1'b0;
			phase_rem   = 0;
			held_valid  = 1'b0;
			held_sample = '0;
		endfunction

		function void set_rate(logic [RATE_W-1:0] v);
			rate_reg = v;
		endfunction

		// rate register saturated to the supported range
		function int unsigned rate_now();
			int unsigned lo;
			int unsigned cur;
			cur = 32'(rate_reg);
			lo = (TGT + 3) / 4;
			if (lo < RATE_FLOOR)
				lo = RATE_FLOOR;
			if (cur < lo)
				return lo;
			if (cur > RATE_CEIL)
				return RATE_CEIL;
			return cur;
		endfunction

		// floored a*(T-r)/T + b*r/T
		function sample_t interp(sample_t a, sample_t b, int unsigned r);
			longint num;
			longint q;
			num = longint'(a) * (longint'(TGT) - longint'(r)) + longint'(b) * longint'(r);
			q = num / TGT;
			if ((num % TGT) != 0 && num < 0)
				q = q - 1;
			return sample_t'(q);
		endfunction

		function void note_sample(sample_t x, logic e);
			result_word_t batch[$];
			result_word_t w;
			int unsigned  rate;
			int unsigned  r;
			sample_t      v;
			rate = rate_now();
			r    = phase_rem;
			samples_seen++;
			if (have_last) begin
				if (held_valid && r <= 2 * TGT) begin
					batch.push_back('{held_sample, 1'b0, 1'b0});
					held_valid = 1'b0;
				end
				while (r < TGT) begin
					v = interp(last_sample, x, r);
					if (r + rate <= 2 * TGT) begin
						if (batch.size() < MAX_RESULTS)
							batch.push_back('{v, 1'b0, 1'b0});
					end else begin
						held_sample = v;
						held_valid  = 1'b1;
					end
					r += rate;
				end
				r -= TGT;
			end
			last_sample = x;
			have_last   = 1'b1;
			if (e) begin
				// trailing outputs clamp to the last sample
				while (r + rate <= TGT) begin
					if (batch.size() < MAX_RESULTS)
						batch.push_back('{x, 1'b0, 1'b0});
					r += rate;
				end
				clear_stream();
			end else begin
				phase_rem = r & 32'h3FFFF;
			end
			if (batch.size() > 0) begin
				w = batch[batch.size() - 1];
				w.run_last    = 1'b1;
				w.stream_done = e;
				batch[batch.size() - 1] = w;
			end
			foreach (batch[i])
				expected_q.push_back(batch[i]);
		endfunction

		function void check_result(sample_t v, logic rl, logic sd);
			result_word_t got;
			result_word_t want;
			got = '{v, rl, sd};
			words_seen++;
			if (sd)
				streams_closed++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: actual sample %0d run_last %b stream_done %b",
					$time, v, rl, sd);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: mismatch: expected sample %0d run_last %b stream_done %b, %s",
					$time, want.value, want.run_last, want.stream_done, "actual below");
				$display("%0t:           actual   sample %0d run_last %b stream_done %b",
					$time, got.value, got.run_last, got.stream_done);
			end
		endfunction

		function void report_leftover();
			if (expected_q.size() != 0) begin
				errors += expected_q.size();
				$display("%0t: %0d expected words never arrived, next expected sample %0d",
					$time, expected_q.size(), expected_q[0].value);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lir_cfg_if cfg();
	lir_in_if  samples();
	lir_out_if results();

	linear_interp_resampler_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.samples (samples),
		.results (results)
	);

	resample_scoreboard sb = new();
	int idle_pct    = IDLE_PCT;
	bit hold_req    = 1'b0;
	int rate_writes = 0;

	always #10 clk = ~clk;

	task automatic settle();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		// a sample that makes no word may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] v);
		cfg.valid   <= 1'b1;
		cfg.rate_hz <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sb.set_rate(v);
		rate_writes++;
	endtask

	task automatic send_sample(input sample_t s, input logic e);
		while ($urandom_range(0, 99) < idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid      <= 1'b1;
		samples.sample_in  <= s;
		samples.stream_end <= e;
		do @(posedge clk); while (!samples.ready);
		sb.note_sample(s, e);
	endtask

	task automatic end_phase();
		samples.valid <= 1'b0;
		settle();
	endtask

	function automatic int unsigned pick_rate();
		case ($urandom_range(0, 9))
			0: return 8000;
			1: return 11025;
			2: return 22050;
			3: return 44100;
			4: return 48000;
			5: return 96000;
			6: return RATE_FLOOR;
			7: return RATE_CEIL;
			8: return $urandom_range(RATE_FLOOR, RATE_CEIL);
			default: return $urandom_range(0, (1 << RATE_W) - 1);
		endcase
	endfunction

	// 0: uniform, 1: small-step ramp, 2: extremes
	function automatic sample_t next_sample(int mode, sample_t prev);
		int tmp;
		case (mode)
			0: return sample_t'($urandom_range(0, 65535));
			1: begin
				tmp = int'(prev) + int'($urandom_range(0, 4095)) - 2048;
				if (tmp > 32767)
					tmp = 32767;
				if (tmp < -32768)
					tmp = -32768;
				return sample_t'(tmp);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
		endcase
	endfunction

	// result side: checks each accepted word, stalls at random
	initial begin
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results.valid && results.ready)
				sb.check_result(results.sample_out, results.run_last, results.stream_done);
			if (hold_req) begin
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			results.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// watchdog on cycles with no handshake on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((cfg.valid && cfg.ready) || (samples.valid && samples.ready)
				|| (results.valid && results.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int      sent;
		int      phase;
		int      n;
		int      mode;
		logic    end_flag;
		sample_t x;
		logic [RATE_W-1:0] rate;

		arst_n             <= 1'b0;
		cfg.valid          <= 1'b0;
		cfg.rate_hz        <= '0;
		samples.valid      <= 1'b0;
		samples.sample_in  <= '0;
		samples.stream_end <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unity rate, sample extremes
		write_rate(RATE_W'(TGT));
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'shFFFF, 1'b1);
		end_phase();

		// lowest rate, fourfold upsampling with tail
		write_rate(RATE_W'(RATE_FLOOR));
		send_sample(16'sd1, 1'b0);
		send_sample(16'sd8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sd12345, 1'b1);
		end_phase();

		// highest rate: one-sample stream gives no word, then held outputs
		write_rate(RATE_W'(RATE_CEIL));
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'shFFFF, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		end_phase();

		// below the floor, stream left open across the next rate changes
		write_rate(18'd100);
		send_sample(16'sd100, 1'b0);
		send_sample(-16'sd100, 1'b0);
		send_sample(16'sd2000, 1'b0);
		end_phase();

		// above the ceiling, mid-stream
		write_rate('1);
		send_sample(-16'sd5000, 1'b0);
		send_sample(16'sd5000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		end_phase();

		// zero rate saturates to the floor, closes the stream
		write_rate('0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		end_phase();

		sent  = 0;
		phase = 0;
		x     = '0;
		while (sent < RANDOM_ITEMS) begin
			rate = (phase == 2) ? RATE_W'(RATE_FLOOR) : RATE_W'(pick_rate());
			write_rate(rate);
			idle_pct = (phase == 1) ? 0 : IDLE_PCT;
			// long output stall while samples keep coming
			if (phase == 2)
				hold_req = 1'b1;
			n    = (phase == 1) ? 30 : $urandom_range(8, 20);
			mode = $urandom_range(0, 2);
			for (int k = 0; k < n; k++) begin
				end_flag = ($urandom_range(0, 11) == 0)
					|| (k == n - 1 && $urandom_range(0, 1) == 1);
				x = next_sample(mode, x);
				send_sample(x, end_flag);
				if (end_flag)
					mode = $urandom_range(0, 2);
			end
			end_phase();
			sent += n;
			phase++;
		end

		sb.report_leftover();
		$display("covered %0d samples and %0d output words over %0d rate writes,",
			sb.samples_seen, sb.words_seen, rate_writes);
		$display("%0d closed streams, out-of-range rates and a long output stall",
			sb.streams_closed);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
src/lir_pkg.sv
src/lir_in_if.sv
src/lir_out_if.sv
src/lir_cfg_if.sv
src/lir_lerp_unit.sv
src/linear_interp_resampler_core.sv
test/tb_top.sv
